// ----- sv/windowed_moving_average_core_assert.svh -----
// Assertion macros shared by the moving average core.
`ifndef WINDOWED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define WMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("moving average core: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("moving average core: next-cycle check failed");

`endif

// ----- sv/wma_pkg.sv -----
// Package with widths, types and codes of the moving average core.
package wma_pkg;

    // Largest window the ring holds.
    localparam int WINDOW_MAX = 256;

    localparam int SAMPLE_W = 32;
    localparam int WIN_W    = 9;
    localparam int POS_W    = $clog2(WINDOW_MAX);
    localparam int CNT_W    = POS_W + 1;
    localparam int SUM_W    = SAMPLE_W + POS_W;
    localparam int DCNT_W   = $clog2(SUM_W);
    localparam int EXT_W    = (WIN_W > CNT_W) ? WIN_W : CNT_W;

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_WINDOW = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic update;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic pass;
        logic div_last;
    } t_dp_stat;

endpackage

// ----- sv/wma_if.sv -----
// Stream interfaces for the sample and average channels.
interface wma_sample_if;
    import wma_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface wma_average_if;
    import wma_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] average_out;
    modport source (output valid, output average_out, input ready);
    modport sink (input valid, input average_out, output ready);
endinterface

// ----- sv/windowed_moving_average_core.sv -----
// Windowed moving average core: top level with configuration port and output register.
//
// Usage:
//   i_sample carries one signed 32-bit sample per item (valid/ready).
//   o_average carries one signed 32-bit truncated mean per accepted item.
//   The APB-style port holds one register, the window length at address 0.
//   Writing it (any value) restarts the filter: sum, slot and fill count clear.
//   A window of zero passes each sample through unchanged.
// Sequence:
//   An averaged item passes through the accepting state, an update step, a
//   divider load, 40 steps of a bit-serial restoring divider (one quotient
//   bit per cycle over the 40-bit sum) and a step that loads the output
//   register once it is free; only then is the next item accepted.
//   A pass-through item goes from acceptance straight to the output load.
// Reset and stall:
//   Synchronous active-low reset clears the window to zero (pass-through),
//   the filter state and the output valid flag. The ring needs no clearing.
//   If the receiver stalls, a finished result waits in the output register
//   while the next item is accepted and computed; that item then waits
//   until the output register frees.
`include "windowed_moving_average_core_assert.svh"

module windowed_moving_average_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wma_sample_if.sink                        i_sample,
    wma_average_if.source                     o_average,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wma_pkg::ADDR_W-1:0]        paddr,
    input  logic [wma_pkg::APB_DW-1:0]        pwdata,
    output logic [wma_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import wma_pkg::*;

    logic [WIN_W-1:0]           r_window;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       cfg_write;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] dp_result;
    t_dp_cmd                    cmd;
    t_dp_stat                   stat;

    // Decode register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_W-1:2] == REG_WINDOW);
    assign prdata    = (paddr[ADDR_W-1:2] == REG_WINDOW) ? APB_DW'(r_window) : '0;

    // Hold the window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (cfg_write) begin
            r_window <= pwdata[WIN_W-1:0];
        end
    end

    wma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (i_sample.ready),
        .o_cmd      (cmd)
    );

    wma_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_write),
        .i_window  (r_window),
        .i_sample  (i_sample.sample_in),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_result  (dp_result)
    );

    // Output register: load a finished item, drop it when taken.
    assign out_free = !r_out_valid || o_average.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_average.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_data <= dp_result;
        end
    end

    assign o_average.valid       = r_out_valid;
    assign o_average.average_out = r_out_data;

    // A result never overwrites one that is still waiting.
    `WMA_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.out_load,
                     !r_out_valid || o_average.ready)
    // In the cycle after an item is accepted the core is busy.
    `WMA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
                     i_sample.valid && i_sample.ready, !i_sample.ready)
    // A result shows up only through a load from the controller.
    `WMA_ASSERT_SAME(a_valid_from_load, i_clk, i_rst_n, $rose(o_average.valid),
                     $past(cmd.out_load))
endmodule

// ----- sv/wma_ram.sv -----
// Generic simple dual-port RAM with registered read.
module wma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read returns old data on collision.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/wma_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module wma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  wma_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output wma_pkg::t_dp_cmd  o_cmd
);
    import wma_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide next state and issue commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.pass ? ST_FINISH : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- sv/wma_dp.sv -----
// Datapath: sample ring, running sum, fill tracking and bit-serial divider.
module wma_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic [wma_pkg::WIN_W-1:0]           i_window,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] i_sample,
    input  wma_pkg::t_dp_cmd                    i_cmd,
    output wma_pkg::t_dp_stat                   o_stat,
    output logic signed [wma_pkg::SAMPLE_W-1:0] o_result
);
    import wma_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_pass;
    logic signed [SUM_W-1:0]    r_sum;
    logic [POS_W-1:0]           r_pos;
    logic [CNT_W-1:0]           r_fill;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic [DCNT_W-1:0]          r_dcnt;

    logic signed [SUM_W-1:0]    n_sum;
    logic [POS_W-1:0]           n_pos;
    logic [CNT_W-1:0]           n_fill;

    logic [EXT_W-1:0]           win_ext;
    logic [CNT_W-1:0]           eff;
    logic [POS_W-1:0]           pos_cur;
    logic [CNT_W-1:0]           pos_inc;
    logic                       full;
    logic [SAMPLE_W-1:0]        old_sample;
    logic [CNT_W-1:0]           rem_shift;
    logic                       rem_ge;
    logic [SUM_W-1:0]           quo_signed;

    // Saturate the window at the ring depth.
    assign win_ext = EXT_W'(i_window);
    assign eff     = (win_ext > EXT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                    : CNT_W'(win_ext);

    // Current slot, oldest sample once the ring is full.
    assign pos_cur = (CNT_W'(r_pos) >= eff) ? '0 : r_pos;
    assign full    = (r_fill >= eff);
    assign pos_inc = CNT_W'(pos_cur) + CNT_W'(1);

    wma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (pos_cur),
        .i_wdata (r_sample),
        .i_raddr (pos_cur),
        .o_rdata (old_sample)
    );

    // Drop the oldest sample once full, add the new one, advance the slot.
    always_comb begin
        n_sum  = r_sum + SUM_W'(r_sample)
                 - (full ? SUM_W'($signed(old_sample)) : SUM_W'(0));
        n_pos  = (pos_inc >= eff) ? '0 : pos_inc[POS_W-1:0];
        n_fill = full ? r_fill : r_fill + CNT_W'(1);
    end

    // Hold filter state, clear on reset and on a window write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else if (i_cmd.update) begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_fill <= n_fill;
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {r_rem[CNT_W-2:0], r_quo[SUM_W-1]};
    assign rem_ge    = (rem_shift >= r_fill);

    // Capture the item and run the divider on the sum magnitude.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_pass   <= (eff == '0);
        end
        if (i_cmd.div_start) begin
            r_neg  <= r_sum[SUM_W-1];
            r_quo  <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(SUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_shift - r_fill : rem_shift;
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    // Apply the sign to truncate toward zero.
    assign quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_result   = r_pass ? r_sample : $signed(quo_signed[SAMPLE_W-1:0]);

    assign o_stat.pass     = (eff == '0);
    assign o_stat.div_last = (r_dcnt == '0);
endmodule

// ----- test/windowed_moving_average_core_checker.sv -----
// Checker for the moving average core: predicts every average and compares it.
`timescale 1ns / 1ps

module windowed_moving_average_core_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wma_sample_if                      i_sample,
    wma_average_if                     i_average,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wma_pkg::ADDR_W-1:0] paddr,
    input  logic [wma_pkg::APB_DW-1:0] pwdata,
    input  logic [wma_pkg::APB_DW-1:0] prdata,
    input  logic                       pready,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked
);
    import wma_pkg::*;

    // Cap the log when the core goes badly wrong.
    localparam int REPORT_CAP = 200;

    logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
    logic signed [SUM_W-1:0]    window_sum;
    logic [POS_W-1:0]           next_slot;
    logic [CNT_W-1:0]           held;
    logic [WIN_W-1:0]           window_len;
    logic signed [SAMPLE_W-1:0] averages_due [$];

    // Clear the running sum, slot and fill count.
    function automatic void restart_filter();
        window_sum = '0;
        next_slot  = '0;
        held       = '0;
    endfunction

    // Push one sample through the filter state and return the truncated mean.
    function automatic logic signed [SAMPLE_W-1:0] filter_step(
        input logic signed [SAMPLE_W-1:0] s
    );
        logic [CNT_W-1:0]        span;
        logic [CNT_W-1:0]        slot;
        logic signed [SUM_W-1:0] mean;
        span = (window_len > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : CNT_W'(window_len);
        // Zero window: pass the sample through, state untouched.
        if (span == '0) begin
            return s;
        end
        slot = CNT_W'(next_slot);
        if (slot >= span) begin
            slot = '0;
        end
        // Drop the oldest sample only once the ring is full.
        if (held >= span) begin
            window_sum = window_sum - history[slot[POS_W-1:0]];
        end
        history[slot[POS_W-1:0]] = s;
        window_sum = window_sum + s;
        slot = slot + 1'b1;
        if (slot >= span) begin
            slot = '0;
        end
        next_slot = slot[POS_W-1:0];
        if (held < span) begin
            held = held + 1'b1;
        end
        // Signed division truncates toward zero.
        mean = window_sum / $signed({1'b0, held});
        return mean[SAMPLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] due;
        if (!i_rst_n) begin
            window_len = '0;
            restart_filter();
            averages_due.delete();
            o_pending = 0;
        end else begin
            // Compare each taken average with the oldest prediction.
            if (i_average.valid && i_average.ready) begin
                if (averages_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_CAP) begin
                        $display("%0t: unexpected average: expected none, got %0d",
                                 $time, i_average.average_out);
                    end
                end else begin
                    due = averages_due.pop_front();
                    o_checked++;
                    if (i_average.average_out !== due) begin
                        o_errors++;
                        if (o_errors <= REPORT_CAP) begin
                            $display("%0t: average mismatch: expected %0d, got %0d",
                                     $time, due, i_average.average_out);
                        end
                    end
                end
            end

            // Predict the average of each accepted item.
            if (i_sample.valid && i_sample.ready) begin
                averages_due.push_back(filter_step(i_sample.sample_in));
            end

            // Check window readback.
            if (psel && penable && pready && !pwrite && paddr[ADDR_W-1:2] == REG_WINDOW
                    && prdata !== APB_DW'(window_len)) begin
                o_errors++;
                if (o_errors <= REPORT_CAP) begin
                    $display("%0t: window readback mismatch: expected %0d, got %0d",
                             $time, window_len, prdata);
                end
            end

            // Any window write restarts the filter; other addresses are ignored.
            if (psel && penable && pready && pwrite && paddr[ADDR_W-1:2] == REG_WINDOW) begin
                window_len = pwdata[WIN_W-1:0];
                restart_filter();
            end

            o_pending = averages_due.size();
        end
    end

endmodule

// ----- test/windowed_moving_average_core_tb.sv -----
// Testbench top for the moving average core: drives samples and window writes.
`timescale 1ns / 1ps

module windowed_moving_average_core_tb;
    import wma_pkg::*;

    localparam int     HALF_PERIOD  = 6;
    localparam int     RESET_CYCLES = 9;
    localparam int     RANDOM_ITEMS = 1250;
    localparam int     DRAIN_CYCLES = 60;
    localparam longint TIMEOUT_NS   = 12_000_000;

    localparam logic [ADDR_W-1:0] ADDR_WINDOW   = {REG_WINDOW, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_WINDOW + ADDR_W'(4);
    localparam int                WINDOW_TOP    = (1 << WIN_W) - 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int send_idle_pct;
    int recv_idle_pct;
    int samples_sent;
    int window_writes;
    int errors;
    int pending;
    int checked;

    wma_sample_if  sample_ch ();
    wma_average_if average_ch ();

    windowed_moving_average_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (sample_ch),
        .o_average (average_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    windowed_moving_average_core_checker CHK (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (sample_ch),
        .i_average (average_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Stall the average channel at random.
    always @(negedge i_clk) begin
        average_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Drive one item after random idle cycles and hold it until taken.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sample_ch.valid     = 1'b0;
            sample_ch.sample_in = $urandom;
            @(negedge i_clk);
        end
        sample_ch.valid     = 1'b1;
        sample_ch.sample_in = value;
        do @(posedge i_clk); while (!sample_ch.ready);
        samples_sent++;
    endtask

    // Drop valid and wait until every predicted average has come out.
    task automatic drain();
        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Wait for the core to go idle, then set a new window (restarts the filter).
    task automatic set_window(input int unsigned win);
        drain();
        apb_write(ADDR_WINDOW, APB_DW'(win));
        window_writes++;
    endtask

    // Mix of rails, small values around zero and full-range noise.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit near_rails);
        logic [SAMPLE_W-1:0] jitter;
        jitter = SAMPLE_W'($urandom_range(0, 15));
        if (near_rails) begin
            return $urandom_range(0, 1) ? SAMPLE_MAX - jitter : SAMPLE_MIN + jitter;
        end
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned win;
        int          span;
        int          len;
        int          count;
        bit          rails;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        average_ch.ready    = 1'b0;
        send_idle_pct       = 6;
        recv_idle_pct       = 84;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pass-through after reset, extremes included.
        apb_read(ADDR_WINDOW);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(-1);

        // Single-sample window.
        set_window(1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);

        // Sum runs past 32 bits, then the ring wraps.
        set_window(3);
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (2) send_sample(SAMPLE_MIN);

        // Above the ring size the window saturates at the full ring.
        set_window(WINDOW_TOP);
        send_sample(SAMPLE_MIN);
        send_sample(-1);

        // Write to an unmapped address leaves the window alone.
        drain();
        apb_write(ADDR_UNMAPPED, APB_DW'(5));
        apb_read(ADDR_WINDOW);
        send_sample(SAMPLE_MAX);

        // Negative mean truncates toward zero; rewriting the same window restarts.
        set_window(2);
        send_sample(-1);
        send_sample(-2);
        set_window(2);
        send_sample(7);

        // Random segments, each under a fresh window.
        count = 0;
        while (count < RANDOM_ITEMS) begin
            if (count >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (count >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 6;
            end
            if (count == 0) begin
                win = WINDOW_MAX;
            end else begin
                case ($urandom_range(0, 9))
                    0: win = 0;
                    1: win = 1;
                    2: win = WINDOW_MAX;
                    3: win = $urandom_range(WINDOW_MAX + 1, WINDOW_TOP);
                    4: win = $urandom_range(1, WINDOW_TOP);
                    default: win = $urandom_range(2, 12);
                endcase
            end
            set_window(win);
            if ($urandom_range(0, 3) == 0) begin
                apb_read(ADDR_WINDOW);
            end
            span = (win > WINDOW_MAX) ? WINDOW_MAX : win;
            // First segment wraps the full ring; later ones wrap small rings a few times.
            if (count == 0) begin
                len = WINDOW_MAX + 40;
            end else if (span > 40) begin
                len = $urandom_range(10, 60);
            end else begin
                len = 2 * span + $urandom_range(1, 16);
            end
            rails = ($urandom_range(0, 3) == 0);
            repeat (len) begin
                send_sample(pick_sample(rails));
                count++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d samples under %0d window writes (pass-through, 1 to %0d, saturated).",
                 samples_sent, window_writes, WINDOW_MAX);
        $display("Checked %0d averages with both channels stalling and free-running.", checked);
        if (errors == 0 && pending == 0) begin
            $display("windowed_moving_average_core_tb OK");
        end else begin
            $display("windowed_moving_average_core_tb NOT OK");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d averages still outstanding.", pending);
        $display("windowed_moving_average_core_tb NOT OK");
        $finish;
    end

endmodule
